@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off during reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (cond) |=> (conseq), msg)

`endif

@@ rtl/core/bbes_pkg.sv @@
// Types, constants and saturation helpers for the block excess summary unit.
// Depends on nothing; the lane, merge, accumulator and top modules import it.
package bbes_pkg;

    // Bits handled by one lane of the prefix scan.
    localparam int LANE_BITS   = 4;
    localparam int LANE_W      = 4;   // signed lane excess, -4..4
    localparam int LANE_CNT_W  = 3;   // lane minimum count, 0..4
    // Chunk-level summary widths, sized for chunks of up to 16 bits.
    localparam int CSUM_W      = 6;   // signed chunk excess, -16..16
    localparam int CCNT_W      = 5;   // chunk minimum count, 0..16
    // Port field widths.
    localparam int CHUNK_W     = 16;
    localparam int NBITS_W     = 5;
    localparam int CFG_W       = 7;
    localparam int OUT_EXC_W   = 12;
    localparam int OUT_CNT_W   = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;

    // Summary of the counted bits of one lane.
    typedef struct packed {
        logic                         any;
        logic signed [LANE_W-1:0]     total;
        logic signed [LANE_W-1:0]     mn;
        logic signed [LANE_W-1:0]     mx;
        logic        [LANE_CNT_W-1:0] cnt;
    } bbes_lane_sum_t;

    // Summary of the counted bits of one chunk.
    typedef struct packed {
        logic                     any;
        logic signed [CSUM_W-1:0] total;
        logic signed [CSUM_W-1:0] mn;
        logic signed [CSUM_W-1:0] mx;
        logic        [CCNT_W-1:0] cnt;
    } bbes_chunk_sum_t;

    // Clamp a signed excess to the 12-bit output range.
    function automatic logic [OUT_EXC_W-1:0] sat_exc(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (r > 32'sd2047)
        begin
            r = 32'sd2047;
        end
        if (r < -32'sd2048)
        begin
            r = -32'sd2048;
        end
        return r[OUT_EXC_W-1:0];
    endfunction

    // Clamp a count to the 11-bit output range.
    function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [31:0] v);
        logic [OUT_CNT_W-1:0] r;
        if (v > 32'd2047)
        begin
            r = 11'd2047;
        end
        else
        begin
            r = v[OUT_CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bbes_lane.sv @@
// One lane of the chunk prefix scan: summarizes four bits into a registered lane summary.
// Depends on bbes_pkg.
module bbes_lane
    import bbes_pkg::*;
(
    input  logic                 clk,
    input  logic                 ld,
    input  logic [LANE_BITS-1:0] bits,   // bit 0 is the earliest
    input  logic [LANE_BITS-1:0] mask,   // 1 marks a counted bit
    output bbes_lane_sum_t       sum
);

    bbes_lane_sum_t              sum_reg;
    bbes_lane_sum_t              sum_next;
    logic signed [LANE_W-1:0]    e;
    logic signed [LANE_W-1:0]    mn;
    logic signed [LANE_W-1:0]    mx;
    logic [LANE_CNT_W-1:0]       cnt;
    logic                        any;

    // Walk the lane's bits in order, tracking excess, extremes and minimum count.
    always_comb
    begin
        e   = '0;
        mn  = '0;
        mx  = '0;
        cnt = '0;
        any = 1'b0;
        for (int j = 0; j < LANE_BITS; j++)
        begin
            if (mask[j])
            begin
                e = bits[j] ? (e + 4'sd1) : (e - 4'sd1);
                if (!any || (e < mn))
                begin
                    mn  = e;
                    cnt = 3'd1;
                end
                else if (e == mn)
                begin
                    cnt = cnt + 3'd1;
                end
                if (!any || (e > mx))
                begin
                    mx = e;
                end
                any = 1'b1;
            end
        end
        sum_next.any   = any;
        sum_next.total = e;
        sum_next.mn    = mn;
        sum_next.mx    = mx;
        sum_next.cnt   = cnt;
    end

    // Lane summary register, loaded when a word is accepted.
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

@@ rtl/core/bbes_merge.sv @@
// Merging stage: combines the lane summaries of one chunk into a registered chunk summary.
// Depends on bbes_pkg.
module bbes_merge
    import bbes_pkg::*;
#(
    parameter int NUM_LANES = 4
)
(
    input  logic            clk,
    input  logic            ld,
    input  bbes_lane_sum_t  lane_sum [NUM_LANES],
    output bbes_chunk_sum_t sum
);

    bbes_chunk_sum_t          sum_reg;
    bbes_chunk_sum_t          sum_next;
    logic signed [CSUM_W-1:0] off;
    logic signed [CSUM_W-1:0] mn;
    logic signed [CSUM_W-1:0] mx;
    logic signed [CSUM_W-1:0] cand_mn;
    logic signed [CSUM_W-1:0] cand_mx;
    logic [CCNT_W-1:0]        cnt;
    logic                     any;

    // Offset each lane by the excess of the lanes before it and fold in order.
    always_comb
    begin
        off     = '0;
        mn      = '0;
        mx      = '0;
        cnt     = '0;
        any     = 1'b0;
        cand_mn = '0;
        cand_mx = '0;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (lane_sum[k].any)
            begin
                cand_mn = off + CSUM_W'(lane_sum[k].mn);
                cand_mx = off + CSUM_W'(lane_sum[k].mx);
                if (!any || (cand_mn < mn))
                begin
                    mn  = cand_mn;
                    cnt = CCNT_W'(lane_sum[k].cnt);
                end
                else if (cand_mn == mn)
                begin
                    cnt = cnt + CCNT_W'(lane_sum[k].cnt);
                end
                if (!any || (cand_mx > mx))
                begin
                    mx = cand_mx;
                end
                off = off + CSUM_W'(lane_sum[k].total);
                any = 1'b1;
            end
        end
        sum_next.any   = any;
        sum_next.total = off;
        sum_next.mn    = mn;
        sum_next.mx    = mx;
        sum_next.cnt   = cnt;
    end

    // Chunk summary register.
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

@@ rtl/core/bbes_accum.sv @@
// Block accumulator: folds chunk summaries into the running block state and
// holds the output register. Depends on bbes_pkg.
module bbes_accum
    import bbes_pkg::*;
#(
    parameter int CHUNK_BITS           = 16,
    parameter int MAX_CHUNKS_PER_BLOCK = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CFG_W-1:0]       cfg,
    input  bbes_chunk_sum_t        sum,
    input  logic                   item_valid,
    input  logic                   item_eos,
    output logic                   item_ready,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data
);

    localparam int SPAN   = MAX_CHUNKS_PER_BLOCK * CHUNK_BITS;
    localparam int EXC_R  = $clog2(SPAN + 1) + 1;
    localparam int EXC_W  = (EXC_R > CSUM_W) ? EXC_R : CSUM_W;
    localparam int NW_R   = $clog2(SPAN + 1);
    localparam int NW     = (NW_R > CCNT_W) ? NW_R : CCNT_W;
    localparam int CW     = $clog2(MAX_CHUNKS_PER_BLOCK + 1);
    localparam int LW     = CW + CFG_W;

    logic signed [EXC_W-1:0] run_exc_reg, run_exc_next;
    logic signed [EXC_W-1:0] run_min_reg, run_min_next;
    logic signed [EXC_W-1:0] run_max_reg, run_max_next;
    logic [NW-1:0]           run_cnt_reg, run_cnt_next;
    logic [CW-1:0]           chunk_cnt_reg, chunk_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic signed [EXC_W-1:0] upd_exc, upd_min, upd_max;
    logic signed [EXC_W-1:0] cand_mn, cand_mx;
    logic [NW-1:0]           upd_cnt;
    logic [CW-1:0]           cnt_inc;
    logic [LW-1:0]           limit;
    logic                    blk_any;
    logic                    emit;
    logic                    take;

    // Effective block length: zero acts as one, large values clamp to the maximum.
    always_comb
    begin
        if (cfg == '0)
        begin
            limit = LW'(1);
        end
        else if (LW'(cfg) > LW'(MAX_CHUNKS_PER_BLOCK))
        begin
            limit = LW'(MAX_CHUNKS_PER_BLOCK);
        end
        else
        begin
            limit = LW'(cfg);
        end
    end

    // Fold the chunk summary into the block, offset by the running excess.
    always_comb
    begin
        blk_any = (run_cnt_reg != '0);
        cand_mn = run_exc_reg + EXC_W'(sum.mn);
        cand_mx = run_exc_reg + EXC_W'(sum.mx);
        upd_exc = run_exc_reg + EXC_W'(sum.total);
        upd_min = run_min_reg;
        upd_max = run_max_reg;
        upd_cnt = run_cnt_reg;
        if (sum.any)
        begin
            if (!blk_any || (cand_mn < run_min_reg))
            begin
                upd_min = cand_mn;
                upd_cnt = NW'(sum.cnt);
            end
            else if (cand_mn == run_min_reg)
            begin
                upd_cnt = run_cnt_reg + NW'(sum.cnt);
            end
            if (!blk_any || (cand_mx > run_max_reg))
            begin
                upd_max = cand_mx;
            end
        end
        cnt_inc    = chunk_cnt_reg + CW'(1);
        emit       = item_eos || (LW'(cnt_inc) >= limit);
        item_ready = !emit || !out_valid_reg || out_ready;
        take       = item_valid && item_ready;
    end

    // Next state of the block and of the output register.
    always_comb
    begin
        run_exc_next   = run_exc_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        run_cnt_next   = run_cnt_reg;
        chunk_cnt_next = chunk_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            if (emit)
            begin
                out_valid_next = 1'b1;
                if (upd_cnt != '0)
                begin
                    out_data_next = {1'b0,
                                     sat_cnt(32'(upd_cnt)),
                                     sat_exc(32'(upd_max)),
                                     sat_exc(32'(upd_min)),
                                     sat_exc(32'(upd_exc))};
                end
                else
                begin
                    out_data_next = '0;
                end
                run_exc_next   = '0;
                run_cnt_next   = '0;
                chunk_cnt_next = '0;
            end
            else
            begin
                run_exc_next   = upd_exc;
                run_min_next   = upd_min;
                run_max_next   = upd_max;
                run_cnt_next   = upd_cnt;
                chunk_cnt_next = cnt_inc;
            end
        end
    end

    // Control state and running excess.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_exc_reg   <= '0;
            run_cnt_reg   <= '0;
            chunk_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_exc_reg   <= run_exc_next;
            run_cnt_reg   <= run_cnt_next;
            chunk_cnt_reg <= chunk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Extremes are only read once the block has a counted bit; output payload.
    always_ff @(posedge clk)
    begin
        run_min_reg  <= run_min_next;
        run_max_reg  <= run_max_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/bit_block_excess_summary_unit.sv @@
// Top level of the block excess summary unit: lanes, merging stage and accumulator.
// Depends on bbes_pkg, bbes_lane, bbes_merge and bbes_accum.
//
// Usage: each word on s_axis carries one chunk of parenthesis bits (earliest bit
// in bit CHUNK_BITS-1, 1 = open) and the number of leading bits that count; tlast
// closes the current block early. Every chunks_per_block words (or at tlast) one
// summary word leaves on m_axis: total, minimum and maximum prefix excess and the
// number of prefixes at the minimum; a block with no counted bits gives all zeros.
// The user writes the block length on the cfg channel only while the unit is idle;
// the unit does not enforce this. Throughput: one word per cycle unless an output
// stall backs up to s_axis. The prefix scan runs as parallel four-bit lanes, a
// merging stage joins them and the accumulator folds one chunk per cycle.
// The last word of a block passes the lane registers, the merge register and the
// output register before its summary is valid on m_axis.
// Reset: chunks_per_block returns to 16, the block is cleared, no word is pending.
// Stall: while m_axis_tready is low the output word holds; the input keeps being
// taken until a word that closes a block meets a full output register, then the
// two pipeline stages fill and s_axis_tready drops.
module bit_block_excess_summary_unit
    import bbes_pkg::*;
#(
    parameter int CHUNK_BITS           = 16,
    parameter int MAX_CHUNKS_PER_BLOCK = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input words.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // chunk[15:0], valid_bits[20:16], zero pad
    input  logic                   s_axis_tlast,   // end_of_stream
    // Summary words.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // total_excess[11:0], min_excess[23:12],
                                                   // max_excess[35:24], min_count[46:36], pad
    // Block length register.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int NUM_LANES = (CHUNK_BITS + LANE_BITS - 1) / LANE_BITS;

    logic                 v1_reg, v1_next;
    logic                 eos1_reg, eos1_next;
    logic                 v2_reg, v2_next;
    logic                 eos2_reg, eos2_next;
    logic [CFG_W-1:0]     cfg_reg, cfg_next;
    logic                 ready_a;
    logic                 ready_b;
    logic                 acc_ready;
    logic                 s_accept;
    logic [NBITS_W-1:0]   nbits;
    logic [LANE_BITS-1:0] lane_bits [NUM_LANES];
    logic [LANE_BITS-1:0] lane_mask [NUM_LANES];
    bbes_lane_sum_t       lane_sum  [NUM_LANES];
    bbes_chunk_sum_t      chunk_sum;

    // Counted bits, clamped to the chunk width.
    assign nbits = (s_axis_tdata[CHUNK_W+NBITS_W-1:CHUNK_W] > NBITS_W'(CHUNK_BITS)) ?
                   NBITS_W'(CHUNK_BITS) : s_axis_tdata[CHUNK_W+NBITS_W-1:CHUNK_W];

    // Deal the chunk's bits out to the lanes in stream order.
    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        for (genvar j = 0; j < LANE_BITS; j++)
        begin : g_bit
            localparam int I = k * LANE_BITS + j;
            if (I < CHUNK_BITS)
            begin : g_used
                assign lane_bits[k][j] = s_axis_tdata[CHUNK_BITS-1-I];
                assign lane_mask[k][j] = (nbits > NBITS_W'(I));
            end
            else
            begin : g_pad
                assign lane_bits[k][j] = 1'b0;
                assign lane_mask[k][j] = 1'b0;
            end
        end

        bbes_lane u_lane
        (
            .clk  (clk),
            .ld   (s_accept),
            .bits (lane_bits[k]),
            .mask (lane_mask[k]),
            .sum  (lane_sum[k])
        );
    end

    bbes_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge
    (
        .clk      (clk),
        .ld       (ready_b && v1_reg),
        .lane_sum (lane_sum),
        .sum      (chunk_sum)
    );

    bbes_accum #(
        .CHUNK_BITS           (CHUNK_BITS),
        .MAX_CHUNKS_PER_BLOCK (MAX_CHUNKS_PER_BLOCK)
    ) u_accum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sum        (chunk_sum),
        .item_valid (v2_reg),
        .item_eos   (eos2_reg),
        .item_ready (acc_ready),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata)
    );

    // Pipeline handshake: a stage loads when it is empty or its word moves on.
    assign ready_b       = !v2_reg || acc_ready;
    assign ready_a       = !v1_reg || ready_b;
    assign s_axis_tready = ready_a;
    assign s_accept      = s_axis_tvalid && ready_a;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        v1_next   = v1_reg;
        eos1_next = eos1_reg;
        v2_next   = v2_reg;
        eos2_next = eos2_reg;
        cfg_next  = cfg_reg;
        if (ready_a)
        begin
            v1_next   = s_axis_tvalid;
            eos1_next = s_axis_tlast;
        end
        if (ready_b)
        begin
            v2_next   = v1_reg;
            eos2_next = eos1_reg;
        end
        if (cfg_valid)
        begin
            cfg_next = cfg_data;
        end
    end

    // Stage valid flags, stream-end marks and the block length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            eos1_reg <= 1'b0;
            v2_reg   <= 1'b0;
            eos2_reg <= 1'b0;
            cfg_reg  <= CFG_RESET;
        end
        else
        begin
            v1_reg   <= v1_next;
            eos1_reg <= eos1_next;
            v2_reg   <= v2_next;
            eos2_reg <= eos2_next;
            cfg_reg  <= cfg_next;
        end
    end

endmodule

@@ rtl/core/bbes_checker.sv @@
// Port-level checks on the summary output of the block excess summary unit, and
// the bind that attaches them to the top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module bbes_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // A stalled summary word stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "summary word dropped while stalled")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "summary word changed while stalled")

    // The final excess is itself a prefix, so it lies between the extremes.
    `ASSERT_CLK(a_order, clk, rst_n, m_axis_tvalid |-> (($signed(m_axis_tdata[23:12]) <= $signed(m_axis_tdata[11:0])) && ($signed(m_axis_tdata[11:0]) <= $signed(m_axis_tdata[35:24]))), "excess outside its own extremes")

    // A block with no counted bits reports zero in every field.
    `ASSERT_CLK(a_empty, clk, rst_n, (m_axis_tvalid && (m_axis_tdata[46:36] == 11'd0)) |-> (m_axis_tdata[35:0] == 36'd0), "empty block with nonzero excess")

endmodule

bind bit_block_excess_summary_unit bbes_checker u_bbes_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
